/* hw/rtl/qvr_pkg.sv */
// Shared constants and types for the quaternion vector rotation pipeline.
package qvr_pkg;

  // Quaternion components are signed Q1.14 in 16 bits.
  localparam int QW    = 16;
  localparam int QFRAC = 14;

  // Squared magnitude, root and normalization widths.
  localparam int N2W  = 2 * QW + 1;        // sum of four squares
  localparam int MAGW = QW + 1;            // floor(sqrt(n2))
  localparam int NUMW = QW + QFRAC;        // |q| << 14 plus half the divisor
  localparam int QNW  = QFRAC + 1;         // normalized magnitude, at most 2^14
  localparam int DVW  = MAGW + QNW;        // shifted divisor

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RESIDUAL = 2'd1,
    STATUS_ZERO     = 2'd2
  } status_e;

endpackage

/* hw/rtl/quaternion_vector_rotation_top.sv */
// Pipelined quaternion normalization and vector rotation, q * a * conj(q).
//
//  channel   | signals                          | contents
//  ----------+----------------------------------+-------------------------------------
//  input     | s_axis_tvalid/tready/tdata/tlast | quaternion, sensor vector, last mark
//  output    | m_axis_tvalid/tready/tdata/tuser | north/east/down, status, last mark
//  config    | cfg_we_i, cfg_wdata_i            | residual limit, no read-back
//
// One transfer is taken per cycle while the output is not stalled. The pipeline has 41
// register stages (input, squares, sum, 17 root stages, dividend, 15 divider stages,
// sign, first products, first sums, second products, output).
// The bit-serial root and divider chains set the depth. Reset clears only the valid
// bits and the limit (to 10). A stall on the output freezes the whole pipeline, so
// nothing is lost or repeated.
module quaternion_vector_rotation_top #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z, zero fill
  input  logic [((4*16+3*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // north_accel, east_accel, down_accel, zero fill
  output logic [((3*(SAMPLE_WIDTH+1)+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int QW    = qvr_pkg::QW;
  localparam int QFRAC = qvr_pkg::QFRAC;
  localparam int N2W   = qvr_pkg::N2W;
  localparam int MAGW  = qvr_pkg::MAGW;
  localparam int NUMW  = qvr_pkg::NUMW;
  localparam int QNW   = qvr_pkg::QNW;
  localparam int DVW   = qvr_pkg::DVW;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int OW   = SW + 1;
  localparam int RTW  = N2W + 1;
  localparam int M1W  = QW + SW;
  localparam int PSW  = SW + 18;
  localparam int PRW  = SW + 4;
  localparam int M2W  = PRW + QW;
  localparam int RSW  = SW + 22;
  localparam int RRW  = SW + 8;
  localparam int DIW  = ((4*16+3*SAMPLE_WIDTH+7)/8)*8;
  localparam int DOW  = ((3*(SAMPLE_WIDTH+1)+7)/8)*8;

  localparam logic signed [RRW-1:0] OMAX = RRW'((64'sd1 <<< (OW-1)) - 64'sd1);
  localparam logic signed [RRW-1:0] OMIN = -OMAX - RRW'(1);

  typedef struct packed {
    logic signed [QW-1:0] qw;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
    logic signed [SW-1:0] ax;
    logic signed [SW-1:0] ay;
    logic signed [SW-1:0] az;
    logic                 last;
    logic                 zero;
  } meta_t;

  // The whole pipeline advances together.
  logic ce;
  assign ce = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  logic [15:0] limit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'd10;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Input register.
  meta_t m0_q;
  logic  v0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (ce) begin
      v0_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      m0_q.qw   <= s_axis_tdata[0*QW +: QW];
      m0_q.qx   <= s_axis_tdata[1*QW +: QW];
      m0_q.qy   <= s_axis_tdata[2*QW +: QW];
      m0_q.qz   <= s_axis_tdata[3*QW +: QW];
      m0_q.ax   <= s_axis_tdata[4*QW +: SW];
      m0_q.ay   <= s_axis_tdata[4*QW+SW +: SW];
      m0_q.az   <= s_axis_tdata[4*QW+2*SW +: SW];
      m0_q.last <= s_axis_tlast;
      m0_q.zero <= 1'b0;
    end
  end

  // Squares.
  meta_t             m1_q;
  logic              v1_q;
  logic [2*QW-2:0]   sq_q [4];
  logic signed [2*QW-1:0] sqw, sqx, sqy, sqz;
  assign sqw = m0_q.qw * m0_q.qw;
  assign sqx = m0_q.qx * m0_q.qx;
  assign sqy = m0_q.qy * m0_q.qy;
  assign sqz = m0_q.qz * m0_q.qz;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ce) begin
      v1_q <= v0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      m1_q     <= m0_q;
      sq_q[0]  <= sqw[2*QW-2:0];
      sq_q[1]  <= sqx[2*QW-2:0];
      sq_q[2]  <= sqy[2*QW-2:0];
      sq_q[3]  <= sqz[2*QW-2:0];
    end
  end

  // Sum of squares.
  meta_t          m2_q;
  meta_t          m2_d;
  logic           v2_q;
  logic [N2W-1:0] n2_q;
  logic [N2W-1:0] n2_d;
  assign n2_d = N2W'(sq_q[0]) + N2W'(sq_q[1]) + N2W'(sq_q[2]) + N2W'(sq_q[3]);
  always_comb begin
    m2_d      = m1_q;
    m2_d.zero = (n2_d == '0);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ce) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      m2_q      <= m2_d;
      n2_q      <= n2_d;
    end
  end

  // Integer square root, one result bit per stage.
  meta_t          ms_q  [MAGW];
  logic           vs_q  [MAGW];
  logic [N2W-1:0] rem_q [MAGW];
  logic [RTW-1:0] root_q[MAGW];

  for (genvar k = 0; k < MAGW; k++) begin : g_sqrt
    meta_t          m_in;
    logic           v_in;
    logic [N2W-1:0] rem_in;
    logic [RTW-1:0] root_in;
    logic [RTW-1:0] bitk;
    logic [RTW-1:0] trial;
    logic           take;

    if (k == 0) begin : g_first
      assign m_in    = m2_q;
      assign v_in    = v2_q;
      assign rem_in  = n2_q;
      assign root_in = '0;
    end else begin : g_next
      assign m_in    = ms_q[k-1];
      assign v_in    = vs_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign bitk  = RTW'(1) << (2 * (MAGW - 1 - k));
    assign trial = root_in + bitk;
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k] <= 1'b0;
      end else if (ce) begin
        vs_q[k] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (ce) begin
        ms_q[k] <= m_in;
        if (take) begin
          rem_q[k]  <= rem_in - trial[N2W-1:0];
          root_q[k] <= (root_in >> 1) + bitk;
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in >> 1;
        end
      end
    end
  end

  // Dividends for the four normalized components.
  logic [MAGW-1:0] mag;
  assign mag = root_q[MAGW-1][MAGW-1:0];

  function automatic logic [QW-1:0] abs_q(input logic signed [QW-1:0] v);
    abs_q = v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

  meta_t           mn_q;
  logic            vn_q;
  logic [NUMW-1:0] num_q [4];
  logic [3:0]      neg_q;
  logic [MAGW-1:0] magn_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (ce) begin
      vn_q <= vs_q[MAGW-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      mn_q     <= ms_q[MAGW-1];
      magn_q   <= mag;
      num_q[0] <= {abs_q(ms_q[MAGW-1].qw), QFRAC'(0)} + NUMW'(mag >> 1);
      num_q[1] <= {abs_q(ms_q[MAGW-1].qx), QFRAC'(0)} + NUMW'(mag >> 1);
      num_q[2] <= {abs_q(ms_q[MAGW-1].qy), QFRAC'(0)} + NUMW'(mag >> 1);
      num_q[3] <= {abs_q(ms_q[MAGW-1].qz), QFRAC'(0)} + NUMW'(mag >> 1);
      neg_q    <= {ms_q[MAGW-1].qz[QW-1], ms_q[MAGW-1].qy[QW-1],
                   ms_q[MAGW-1].qx[QW-1], ms_q[MAGW-1].qw[QW-1]};
    end
  end

  // Restoring divider, one quotient bit per stage, four lanes sharing the divisor.
  meta_t           md_q   [QNW];
  logic            vd_q   [QNW];
  logic [MAGW-1:0] magd_q [QNW];
  logic [3:0]      negd_q [QNW];
  logic [NUMW-1:0] drem_q [QNW][4];
  logic [QNW-1:0]  quo_q  [QNW][4];

  for (genvar j = 0; j < QNW; j++) begin : g_div
    meta_t           m_in;
    logic            v_in;
    logic [MAGW-1:0] mag_in;
    logic [3:0]      neg_in;
    logic [NUMW-1:0] rem_in [4];
    logic [QNW-1:0]  quo_in [4];
    logic [DVW-1:0]  dvs;

    if (j == 0) begin : g_first
      assign m_in   = mn_q;
      assign v_in   = vn_q;
      assign mag_in = magn_q;
      assign neg_in = neg_q;
      for (genvar l = 0; l < 4; l++) begin : g_l
        assign rem_in[l] = num_q[l];
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign m_in   = md_q[j-1];
      assign v_in   = vd_q[j-1];
      assign mag_in = magd_q[j-1];
      assign neg_in = negd_q[j-1];
      for (genvar l = 0; l < 4; l++) begin : g_l
        assign rem_in[l] = drem_q[j-1][l];
        assign quo_in[l] = quo_q[j-1][l];
      end
    end

    assign dvs = DVW'(mag_in) << (QNW - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[j] <= 1'b0;
      end else if (ce) begin
        vd_q[j] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (ce) begin
        md_q[j]   <= m_in;
        magd_q[j] <= mag_in;
        negd_q[j] <= neg_in;
        for (int l = 0; l < 4; l++) begin
          if (DVW'(rem_in[l]) >= dvs) begin
            drem_q[j][l] <= rem_in[l] - dvs[NUMW-1:0];
            quo_q[j][l]  <= quo_in[l] | (QNW'(1) << (QNW - 1 - j));
          end else begin
            drem_q[j][l] <= rem_in[l];
            quo_q[j][l]  <= quo_in[l];
          end
        end
      end
    end
  end

  // Restore the signs of the normalized components.
  meta_t                mg_q;
  logic                 vg_q;
  logic signed [QW-1:0] nq_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (ce) begin
      vg_q <= vd_q[QNW-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      mg_q <= md_q[QNW-1];
      for (int l = 0; l < 4; l++) begin
        nq_q[l] <= negd_q[QNW-1][l] ? -QW'(quo_q[QNW-1][l]) : QW'(quo_q[QNW-1][l]);
      end
    end
  end

  // First product qn * (0, a).
  meta_t                 m3_q;
  logic                  v3_q;
  logic signed [QW-1:0]  n3_q [4];
  logic signed [M1W-1:0] pr1_q [12];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ce) begin
      v3_q <= vg_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      m3_q      <= mg_q;
      n3_q      <= nq_q;
      pr1_q[0]  <= nq_q[1] * mg_q.ax;
      pr1_q[1]  <= nq_q[2] * mg_q.ay;
      pr1_q[2]  <= nq_q[3] * mg_q.az;
      pr1_q[3]  <= nq_q[0] * mg_q.ax;
      pr1_q[4]  <= nq_q[2] * mg_q.az;
      pr1_q[5]  <= nq_q[3] * mg_q.ay;
      pr1_q[6]  <= nq_q[0] * mg_q.ay;
      pr1_q[7]  <= nq_q[3] * mg_q.ax;
      pr1_q[8]  <= nq_q[1] * mg_q.az;
      pr1_q[9]  <= nq_q[0] * mg_q.az;
      pr1_q[10] <= nq_q[1] * mg_q.ay;
      pr1_q[11] <= nq_q[2] * mg_q.ax;
    end
  end

  // Round half away from zero from Q14 to counts.
  function automatic logic signed [PRW-1:0] rnd_p(input logic signed [PSW-1:0] v);
    logic [PSW-1:0] m;
    logic [PSW-1:0] u;
    m = v[PSW-1] ? PSW'(-v) : PSW'(v);
    u = (m + PSW'(1 << (QFRAC - 1))) >> QFRAC;
    rnd_p = v[PSW-1] ? -PRW'(u) : PRW'(u);
  endfunction

  function automatic logic signed [RRW-1:0] rnd_r(input logic signed [RSW-1:0] v);
    logic [RSW-1:0] m;
    logic [RSW-1:0] u;
    m = v[RSW-1] ? RSW'(-v) : RSW'(v);
    u = (m + RSW'(1 << (QFRAC - 1))) >> QFRAC;
    rnd_r = v[RSW-1] ? -RRW'(u) : RRW'(u);
  endfunction

  function automatic logic signed [PSW-1:0] ep(input logic signed [M1W-1:0] v);
    ep = PSW'(v);
  endfunction

  meta_t                 m4_q;
  logic                  v4_q;
  logic signed [QW-1:0]  n4_q [4];
  logic signed [PRW-1:0] p_q  [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ce) begin
      v4_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      m4_q   <= m3_q;
      n4_q   <= n3_q;
      p_q[0] <= rnd_p(-ep(pr1_q[0]) - ep(pr1_q[1]) - ep(pr1_q[2]));
      p_q[1] <= rnd_p(ep(pr1_q[3]) + ep(pr1_q[4]) - ep(pr1_q[5]));
      p_q[2] <= rnd_p(ep(pr1_q[6]) + ep(pr1_q[7]) - ep(pr1_q[8]));
      p_q[3] <= rnd_p(ep(pr1_q[9]) + ep(pr1_q[10]) - ep(pr1_q[11]));
    end
  end

  // Second product p * conj(qn).
  meta_t                 m5_q;
  logic                  v5_q;
  logic signed [M2W-1:0] pr2_q [16];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (ce) begin
      v5_q <= v4_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      m5_q      <= m4_q;
      pr2_q[0]  <= p_q[0] * n4_q[0];
      pr2_q[1]  <= p_q[1] * n4_q[1];
      pr2_q[2]  <= p_q[2] * n4_q[2];
      pr2_q[3]  <= p_q[3] * n4_q[3];
      pr2_q[4]  <= p_q[1] * n4_q[0];
      pr2_q[5]  <= p_q[0] * n4_q[1];
      pr2_q[6]  <= p_q[2] * n4_q[3];
      pr2_q[7]  <= p_q[3] * n4_q[2];
      pr2_q[8]  <= p_q[2] * n4_q[0];
      pr2_q[9]  <= p_q[0] * n4_q[2];
      pr2_q[10] <= p_q[3] * n4_q[1];
      pr2_q[11] <= p_q[1] * n4_q[3];
      pr2_q[12] <= p_q[3] * n4_q[0];
      pr2_q[13] <= p_q[0] * n4_q[3];
      pr2_q[14] <= p_q[1] * n4_q[2];
      pr2_q[15] <= p_q[2] * n4_q[1];
    end
  end

  function automatic logic signed [RSW-1:0] er(input logic signed [M2W-1:0] v);
    er = RSW'(v);
  endfunction

  function automatic logic signed [OW-1:0] clamp(input logic signed [RRW-1:0] v);
    priority if (v > OMAX) begin
      clamp = OW'(OMAX);
    end else if (v < OMIN) begin
      clamp = OW'(OMIN);
    end else begin
      clamp = OW'(v);
    end
  endfunction

  logic signed [RRW-1:0] rw, rn, re, rd;
  logic [RRW-1:0]        rw_mag;
  assign rw = rnd_r(er(pr2_q[0]) + er(pr2_q[1]) + er(pr2_q[2]) + er(pr2_q[3]));
  assign rn = rnd_r(er(pr2_q[4]) - er(pr2_q[5]) - er(pr2_q[6]) + er(pr2_q[7]));
  assign re = rnd_r(er(pr2_q[8]) - er(pr2_q[9]) - er(pr2_q[10]) + er(pr2_q[11]));
  assign rd = rnd_r(er(pr2_q[12]) - er(pr2_q[13]) - er(pr2_q[14]) + er(pr2_q[15]));
  assign rw_mag = rw[RRW-1] ? RRW'(-rw) : RRW'(rw);

  // Output register.
  logic signed [OW-1:0] north_q, east_q, down_q;
  qvr_pkg::status_e     status_q;
  logic                 last_q;
  logic                 vo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (ce) begin
      vo_q <= v5_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      last_q <= m5_q.last;
      if (m5_q.zero) begin
        north_q  <= '0;
        east_q   <= '0;
        down_q   <= '0;
        status_q <= qvr_pkg::STATUS_ZERO;
      end else begin
        north_q  <= clamp(rn);
        east_q   <= clamp(re);
        down_q   <= clamp(rd);
        status_q <= (rw_mag > RRW'(limit_q)) ? qvr_pkg::STATUS_RESIDUAL
                                              : qvr_pkg::STATUS_OK;
      end
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = DOW'({down_q, east_q, north_q});
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;

endmodule

/* tb/quaternion_vector_rotation_top_tb.sv */
// Self-checking testbench for the quaternion vector rotation pipeline.
module quaternion_vector_rotation_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW         = 16;
  localparam int OW         = SW + 1;
  localparam int LATENCY    = 40;
  localparam int MAX_CYCLES = 600000;

  typedef struct packed {
    logic signed [OW-1:0] north;
    logic signed [OW-1:0] east;
    logic signed [OW-1:0] down;
    qvr_pkg::status_e     status;
    logic                 last;
  } ned_t;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [SW-1:0] ax, ay, az;
    logic last;
    bit   has_ned;
    ned_t ned;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  quaternion_vector_rotation_top #(.SAMPLE_WIDTH(SW)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ned_t        pending_ned[$];
  ned_t        typed_ned[$];
  bit          typed_valid[$];
  logic [15:0] limit_shadow = 16'd10;
  int          errors = 0;
  int          results_seen = 0;
  int          status_seen[3] = '{0, 0, 0};
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;
  sample_t     next_row;

  // Rounds v / 2^14 half away from zero.
  function automatic longint round_q14(longint v);
    longint u;
    u = ((v < 0 ? -v : v) + 8192) >>> 14;
    return v < 0 ? -u : u;
  endfunction

  function automatic longint norm_part(longint q, longint m);
    longint u;
    u = (((q < 0 ? -q : q) <<< 14) + (m >>> 1)) / m;
    return q < 0 ? -u : u;
  endfunction

  function automatic logic signed [OW-1:0] clamp_ned(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (OW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OW-1:0];
  endfunction

  function automatic ned_t rotate_to_ned(logic [111:0] d, logic lst, logic [15:0] lim);
    longint w, x, y, z, ax, ay, az, n2, mag, rem, bitv;
    longint nw, nx, ny, nz, pw, px, py, pz, rw;
    ned_t   r;
    w  = longint'($signed(d[15:0]));
    x  = longint'($signed(d[31:16]));
    y  = longint'($signed(d[47:32]));
    z  = longint'($signed(d[63:48]));
    ax = longint'($signed(d[79:64]));
    ay = longint'($signed(d[95:80]));
    az = longint'($signed(d[111:96]));
    n2 = w*w + x*x + y*y + z*z;
    // Digit-by-digit integer square root.
    rem = n2;
    mag = 0;
    bitv = longint'(1) <<< 40;
    while (bitv > rem) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (rem >= mag + bitv) begin
        rem = rem - (mag + bitv);
        mag = (mag >>> 1) + bitv;
      end else begin
        mag = mag >>> 1;
      end
      bitv = bitv >>> 2;
    end
    r.last = lst;
    if (mag == 0) begin
      r.north = '0; r.east = '0; r.down = '0;
      r.status = qvr_pkg::STATUS_ZERO;
      return r;
    end
    nw = norm_part(w, mag); nx = norm_part(x, mag);
    ny = norm_part(y, mag); nz = norm_part(z, mag);
    pw = round_q14(-nx*ax - ny*ay - nz*az);
    px = round_q14(nw*ax + ny*az - nz*ay);
    py = round_q14(nw*ay + nz*ax - nx*az);
    pz = round_q14(nw*az + nx*ay - ny*ax);
    rw = round_q14(pw*nw + px*nx + py*ny + pz*nz);
    r.north = clamp_ned(round_q14(px*nw - pw*nx - py*nz + pz*ny));
    r.east  = clamp_ned(round_q14(py*nw - pw*ny - pz*nx + px*nz));
    r.down  = clamp_ned(round_q14(pz*nw - pw*nz - px*ny + py*nx));
    r.status = ((rw < 0 ? -rw : rw) > longint'(lim)) ? qvr_pkg::STATUS_RESIDUAL
                                                     : qvr_pkg::STATUS_OK;
    return r;
  endfunction

  // Input transfers feed the predictor; config writes update its copy of the limit.
  always @(posedge clk_i) begin
    if (cfg_we_i) limit_shadow <= cfg_wdata_i;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_ned.push_back(rotate_to_ned(s_axis_tdata, s_axis_tlast, limit_shadow));
  end

  // Output transfers are compared with the oldest prediction.
  always @(posedge clk_i) begin
    ned_t got, want, typed;
    bit   has_typed;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.north  = m_axis_tdata[16:0];
      got.east   = m_axis_tdata[33:17];
      got.down   = m_axis_tdata[50:34];
      got.status = qvr_pkg::status_e'(m_axis_tuser);
      got.last   = m_axis_tlast;
      if (pending_ned.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        want = pending_ned.pop_front();
        has_typed = 1'b0;
        if (typed_valid.size() > 0) begin
          has_typed = typed_valid.pop_front();
          typed = typed_ned.pop_front();
        end
        if (has_typed && typed != want) begin
          errors++;
          $display("%0t: table expects %p, predictor %p", $time, typed, want);
        end
        if (got.north != want.north || got.east != want.east ||
            got.down != want.down || got.status != want.status ||
            got.last != want.last) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
        end
        if (got.status <= qvr_pkg::STATUS_ZERO) status_seen[got.status]++;
        results_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s.az, s.ay, s.ax, s.qz, s.qy, s.qx, s.qw};
    s_axis_tlast  <= s.last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_ned.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int kind;
    kind = int'($urandom_range(19));
    s.qw = 16'($urandom); s.qx = 16'($urandom); s.qy = 16'($urandom); s.qz = 16'($urandom);
    s.ax = SW'($urandom); s.ay = SW'($urandom); s.az = SW'($urandom);
    s.last = 1'($urandom_range(1));
    s.has_ned = 1'b0;
    if (kind == 0) begin
      s.qw = '0; s.qx = '0; s.qy = '0; s.qz = '0;
    end else if (kind < 3) begin
      s.qw = 16'($signed(4'($urandom))); s.qx = 16'($signed(4'($urandom)));
      s.qy = 16'($signed(4'($urandom))); s.qz = 16'($signed(4'($urandom)));
    end else if (kind < 5) begin
      s.ax = SW'($signed(6'($urandom))); s.ay = SW'($signed(6'($urandom)));
      s.az = SW'($signed(6'($urandom)));
    end
    return s;
  endfunction

  function automatic sample_t make_row(int qw, int qx, int qy, int qz,
                                       int ax, int ay, int az, bit lst);
    sample_t s;
    s.qw = 16'(qw); s.qx = 16'(qx); s.qy = 16'(qy); s.qz = 16'(qz);
    s.ax = SW'(ax); s.ay = SW'(ay); s.az = SW'(az);
    s.last = lst;
    s.has_ned = 1'b0;
    s.ned = '0;
    return s;
  endfunction

  sample_t directed_rows[$];

  initial begin
    int   count;
    // Zero quaternion and the identity rotation have results that can be typed in.
    next_row = make_row(0, 0, 0, 0, 32767, -32768, 1234, 1);
    next_row.has_ned = 1'b1;
    next_row.ned = '{north: '0, east: '0, down: '0, status: qvr_pkg::STATUS_ZERO,
                     last: 1'b1};
    directed_rows.push_back(next_row);
    next_row = make_row(16384, 0, 0, 0, 100, -200, 300, 0);
    next_row.has_ned = 1'b1;
    next_row.ned = '{north: OW'(100), east: -OW'(200), down: OW'(300),
                     status: qvr_pkg::STATUS_OK, last: 1'b0};
    directed_rows.push_back(next_row);
    next_row = make_row(-16384, 0, 0, 0, 32767, -32768, 32767, 1);
    next_row.has_ned = 1'b1;
    next_row.ned = '{north: OW'(32767), east: -OW'(32768), down: OW'(32767),
                     status: qvr_pkg::STATUS_OK, last: 1'b1};
    directed_rows.push_back(next_row);
    directed_rows.push_back(make_row(-32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, 0));
    directed_rows.push_back(make_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1));
    directed_rows.push_back(make_row(0, 32767, 0, 0, 1000, 2000, 3000, 0));
    directed_rows.push_back(make_row(0, 0, -32768, 0, -32768, 32767, -1, 0));
    directed_rows.push_back(make_row(0, 0, 0, 32767, 12345, -54, 7, 1));
    directed_rows.push_back(make_row(1, 0, 0, 0, -1, 1, -1, 0));
    directed_rows.push_back(make_row(1, 1, 1, 1, 32767, 32767, -32768, 0));
    directed_rows.push_back(make_row(11585, 11585, 0, 0, 32767, 0, -32768, 1));
    directed_rows.push_back(make_row(8192, -8192, 8192, -8192, -32768, -32768, 32767, 0));
    directed_rows.push_back(make_row(-1, 0, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(make_row(3, -4, 0, 0, 21845, -21846, 3, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs with the limit at its reset value.
    foreach (directed_rows[i]) begin
      typed_valid.push_back(directed_rows[i].has_ned);
      typed_ned.push_back(directed_rows[i].ned);
      send_sample(directed_rows[i]);
    end
    drain_results();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin write_limit(16'd0);     send_idle_pct = 0;  stall_pct = 0;  end
        1: begin write_limit(16'd65535); send_idle_pct = 75; stall_pct = 0;  end
        2: begin write_limit(16'd1);     send_idle_pct = 0;  stall_pct = 75; end
        3: begin write_limit(16'($urandom)); send_idle_pct = 23; stall_pct = 23; end
        4: begin write_limit(16'd2);     send_idle_pct = 0;  stall_pct = 0;
                 hold_cycles = 400; end
        5: begin write_limit(16'd10);    send_idle_pct = 23; stall_pct = 23; end
        default: begin write_limit(16'($urandom_range(5))); send_idle_pct = 0;
                 stall_pct = 75; end
      endcase
      count = (phase == 4) ? 300 : 230;
      repeat (count) send_sample(random_sample());
      drain_results();
    end

    $display("Ran %0d results over seven limit settings with sender gaps and receiver stalls.",
             results_seen);
    $display("Status counts: ok %0d, residual %0d, zero quaternion %0d.",
             status_seen[0], status_seen[1], status_seen[2]);
    if (errors == 0 && pending_ned.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
